### src/midi_note_event_processor_defines.svh
// Assertion macros used by the note event processor back end.
`ifndef MIDI_NOTE_EVENT_PROCESSOR_DEFINES_SVH
`define MIDI_NOTE_EVENT_PROCESSOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define MNEP_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MNEP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MNEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/mnep_pkg.sv
// Types and constants of the MIDI note event processor.
package mnep_pkg;

  localparam int VEL_MID     = 63;
  localparam int VEL_MAX     = 127;
  localparam int NOTE_SLOTS  = 128;
  localparam int NOTE_W      = $clog2(NOTE_SLOTS);
  localparam int DIV3_RECIP  = 171;  // ceil(512/3), exact for values below 512
  localparam int DIV3_SHIFT  = 9;

  localparam int MAX_RELEASE_DEFAULT = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] TYPE_ON  = 8'h90;
  localparam logic [7:0] TYPE_OFF = 8'h80;
  // temporary edit types, never forwarded
  localparam logic [7:0] TYPE_TMP_A = 8'h8F;
  localparam logic [7:0] TYPE_TMP_B = 8'h7F;
  localparam logic [7:0] TYPE_TMP_C = 8'hAF;
  localparam logic [7:0] TYPE_TMP_D = 8'hDF;

  localparam logic [2:0] CM_NONE  = 3'd0;
  localparam logic [2:0] CM_DIV1  = 3'd1;
  localparam logic [2:0] CM_DIV2  = 3'd2;
  localparam logic [2:0] CM_DIV3  = 3'd3;
  localparam logic [2:0] CM_FORCE = 3'd4;

  localparam logic [1:0] CFG_CHANNEL    = 2'd0;
  localparam logic [1:0] CFG_TRANSPOSE  = 2'd1;
  localparam logic [1:0] CFG_COMPRESS   = 2'd2;
  localparam logic [1:0] CFG_VEL_OFFSET = 2'd3;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_RELEASE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] msg_type;
    logic [7:0] data_one;
    logic [7:0] data_two;
  } cmd_t;

  // channel sits in the lowest bits
  typedef struct packed {
    logic [7:0] held_count;
    logic [7:0] data_two;
    logic [7:0] data_one;
    logic [7:0] msg_type;
    logic [4:0] channel;
  } res_t;

endpackage

### src/mnep_front.sv
// Front end: accepts events, drops edit types, transposes and shapes velocity.
module mnep_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tuser,   // [0] mode
  input  logic [23:0]           in_tdata,   // [7:0] msg_type, [15:8] data_one, [23:16] data_two
  input  logic signed [7:0]     transpose,
  input  logic [2:0]            compress_mode,
  input  logic signed [7:0]     velocity_offset,
  input  logic                  q_full,
  output logic                  q_push,
  output mnep_pkg::cmd_t        q_cmd
);

  logic [7:0]         msg_type;
  logic [7:0]         data_one;
  logic [7:0]         data_two;
  logic               drop;
  logic signed [8:0]  vel_diff;
  logic [7:0]         mag;
  logic [15:0]        prod;
  logic [7:0]         quo;
  logic signed [9:0]  squo;
  logic signed [10:0] base;
  logic signed [10:0] sum;
  logic [7:0]         vel;
  logic               shape_en;

  assign msg_type = in_tdata[7:0];
  assign data_one = in_tdata[15:8];
  assign data_two = in_tdata[23:16];

  always_comb begin
    drop = !in_tuser && (msg_type inside {mnep_pkg::TYPE_TMP_A, mnep_pkg::TYPE_TMP_B,
                                          mnep_pkg::TYPE_TMP_C, mnep_pkg::TYPE_TMP_D});
  end

  // velocity: compress toward mid, add offset, clamp
  always_comb begin
    vel_diff = $signed({1'b0, data_two}) - $signed(9'(mnep_pkg::VEL_MID));
    mag  = vel_diff[8] ? 8'(-vel_diff) : 8'(vel_diff);
    prod = 16'(mag) * 16'(mnep_pkg::DIV3_RECIP);
    case (compress_mode)
      mnep_pkg::CM_DIV2: quo = mag >> 1;
      mnep_pkg::CM_DIV3: quo = 8'(prod >> mnep_pkg::DIV3_SHIFT);
      default:           quo = mag;
    endcase
    squo = vel_diff[8] ? (10'sd0 - $signed({2'b00, quo})) : $signed({2'b00, quo});
    if (compress_mode inside {[mnep_pkg::CM_DIV1:mnep_pkg::CM_DIV3]}) begin
      base = $signed(11'(mnep_pkg::VEL_MID)) + 11'(squo);
    end else if (compress_mode == mnep_pkg::CM_FORCE) begin
      base = $signed(11'(mnep_pkg::VEL_MID));
    end else begin
      base = $signed({3'b000, data_two});
    end
    sum = base + 11'(velocity_offset);
    if (sum < 0) begin
      vel = 8'd0;
    end else if (sum > $signed(11'(mnep_pkg::VEL_MAX))) begin
      vel = 8'(mnep_pkg::VEL_MAX);
    end else begin
      vel = sum[7:0];
    end
    shape_en = (compress_mode inside {[mnep_pkg::CM_DIV1:mnep_pkg::CM_FORCE]}) ||
               (velocity_offset != 8'sd0);
  end

  always_comb begin
    q_cmd.msg_type = msg_type;
    q_cmd.data_one = data_one;
    q_cmd.data_two = data_two;
    if (in_tuser) begin
      q_cmd.kind = mnep_pkg::CMD_RELEASE;
    end else if (msg_type == mnep_pkg::TYPE_ON) begin
      q_cmd.kind     = mnep_pkg::CMD_NOTE_ON;
      q_cmd.data_one = data_one + $unsigned(transpose);
      if (shape_en) begin
        q_cmd.data_two = vel;
      end
    end else if (msg_type == mnep_pkg::TYPE_OFF) begin
      q_cmd.kind     = mnep_pkg::CMD_NOTE_OFF;
      q_cmd.data_one = data_one + $unsigned(transpose);
    end else begin
      q_cmd.kind = mnep_pkg::CMD_PASS;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && !drop;

endmodule

### src/mnep_queue.sv
// Short command queue between front and back end.
module mnep_queue #(
  parameter int DEPTH = mnep_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mnep_pkg::cmd_t push_cmd,
  input  logic           pop,
  output mnep_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mnep_pkg::cmd_t slots_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_nxt  = push ? bump(wr_r) : wr_r;
    rd_nxt  = pop ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_cmd;
    end
  end

  assign pop_cmd   = slots_r[rd_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);

endmodule

### src/mnep_back.sv
// Back end: held-note map, release scan and output register.
`include "midi_note_event_processor_defines.svh"

module mnep_back #(
  parameter int MAX_RELEASE = mnep_pkg::MAX_RELEASE_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [4:0]     channel,
  input  logic           q_valid,
  input  mnep_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output mnep_pkg::res_t out_res,
  output logic           out_last
);

  localparam int NW = mnep_pkg::NOTE_W;
  localparam int CW = $clog2(MAX_RELEASE + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t                          state_r, state_nxt;
  logic [mnep_pkg::NOTE_SLOTS-1:0] held_r, held_nxt;
  logic [7:0]                      total_r, total_nxt;
  logic [NW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [NW-1:0]                   pend_note_r, pend_note_nxt;
  logic [7:0]                      pend_held_r, pend_held_nxt;
  logic                            left_r, left_nxt;
  logic                            out_valid_r, out_valid_nxt;
  mnep_pkg::res_t                  out_res_r, out_res_nxt;
  logic                            out_last_r, out_last_nxt;

  logic       slot_free;
  logic       hit;
  logic [7:0] total_dec;
  logic       in_map;

  assign slot_free = !out_valid_r || out_ready;
  assign hit       = held_r[idx_r];
  assign total_dec = (total_r != 8'd0) ? total_r - 8'd1 : 8'd0;
  assign in_map    = !q_cmd.data_one[7];

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_note_nxt = pend_note_r;
    pend_held_nxt = pend_held_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_cmd.kind == mnep_pkg::CMD_RELEASE) begin
            state_nxt  = ST_SCAN;
            idx_nxt    = '0;
            cnt_nxt    = '0;
            pend_v_nxt = 1'b0;
            left_nxt   = 1'b0;
          end else begin
            if (q_cmd.kind == mnep_pkg::CMD_NOTE_ON && in_map &&
                !held_r[q_cmd.data_one[NW-1:0]]) begin
              held_nxt[q_cmd.data_one[NW-1:0]] = 1'b1;
              total_nxt = total_r + 8'd1;
            end else if (q_cmd.kind == mnep_pkg::CMD_NOTE_OFF && in_map &&
                         held_r[q_cmd.data_one[NW-1:0]]) begin
              held_nxt[q_cmd.data_one[NW-1:0]] = 1'b0;
              total_nxt = total_dec;
            end
            out_valid_nxt          = 1'b1;
            out_res_nxt.channel    = channel;
            out_res_nxt.msg_type   = q_cmd.msg_type;
            out_res_nxt.data_one   = q_cmd.data_one;
            out_res_nxt.data_two   = q_cmd.data_two;
            out_res_nxt.held_count = total_nxt;
            out_last_nxt           = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        if (hit && cnt_r == CW'(MAX_RELEASE)) begin
          // limit reached with notes still held
          left_nxt  = 1'b1;
          state_nxt = ST_FLUSH;
        end else if (!hit || !pend_v_r || slot_free) begin
          if (hit) begin
            // previous note-off is not the last one: send it now
            if (pend_v_r) begin
              out_valid_nxt          = 1'b1;
              out_res_nxt.channel    = channel;
              out_res_nxt.msg_type   = mnep_pkg::TYPE_OFF;
              out_res_nxt.data_one   = {1'b0, pend_note_r};
              out_res_nxt.data_two   = 8'd0;
              out_res_nxt.held_count = pend_held_r;
              out_last_nxt           = 1'b0;
            end
            held_nxt[idx_r] = 1'b0;
            total_nxt       = total_dec;
            pend_v_nxt      = 1'b1;
            pend_note_nxt   = idx_r;
            pend_held_nxt   = total_dec;
            cnt_nxt         = cnt_r + CW'(1);
          end
          if (idx_r == NW'(mnep_pkg::NOTE_SLOTS - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + NW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r || slot_free) begin
          if (!left_r) begin
            total_nxt = 8'd0;
          end
          if (pend_v_r) begin
            out_valid_nxt          = 1'b1;
            out_res_nxt.channel    = channel;
            out_res_nxt.msg_type   = mnep_pkg::TYPE_OFF;
            out_res_nxt.data_one   = {1'b0, pend_note_r};
            out_res_nxt.data_two   = 8'd0;
            out_res_nxt.held_count = left_r ? total_r : 8'd0;
            out_last_nxt           = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      total_r     <= 8'd0;
      pend_v_r    <= 1'b0;
      left_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      total_r     <= total_nxt;
      pend_v_r    <= pend_v_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    pend_note_r <= pend_note_nxt;
    pend_held_r <= pend_held_nxt;
    out_res_r   <= out_res_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

  `MNEP_ASSERT_HOLDS(a_total_matches_map, $countones(held_r) == 32'(total_r), "held count out of step with note map")
  `MNEP_ASSERT_IMPL(a_scan_count_bound, state_r == ST_SCAN, cnt_r <= CW'(MAX_RELEASE), "release count past limit")
  `MNEP_ASSERT_IMPL(a_full_scan_clears, state_r == ST_FLUSH && !left_r, held_r == '0, "notes left after full scan")
  `MNEP_ASSERT_NEXT(a_note_on_marks, q_pop && q_cmd.kind == mnep_pkg::CMD_NOTE_ON && in_map, held_r[$past(q_cmd.data_one[NW-1:0])], "note-on did not mark note")

endmodule

### src/midi_note_event_processor.sv
// MIDI note event processor top level: configuration registers and wiring.
//
// Input stream: in_tdata carries msg_type, data_one, data_two; in_tuser is the
// mode bit (0 forward one event, 1 release held notes). Output stream gives one
// event per transaction with out_tlast on the final result of each input.
// Configuration: cfg_index selects channel, transpose, compress_mode or
// velocity_offset; cfg_data is written when cfg_valid is high (cfg_ready is
// always high). Write it only while the block is idle.
// A forwarded event passes the command queue, then the output register, before
// it shows on out_tvalid. Forwarding sustains one event per clock while out_tready
// is high and no release runs; a small command queue decouples front and back end.
// A release scans the held-note map one note per clock unless a note-off stalls
// at the output; it sweeps up to 128 slots, fewer once the per-item limit is
// reached, and gives one note-off per held note that it clears.
// Reset clears the held-note map, the held count and the queue; configuration
// returns to channel 1 with no transpose, compression or offset.
// When the receiver stalls, the output register holds its result, the back end
// stops, the queue fills and in_tready falls.
module midi_note_event_processor #(
  parameter int MAX_RELEASE_PER_ITEM = mnep_pkg::MAX_RELEASE_DEFAULT,
  parameter int QUEUE_DEPTH          = mnep_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] msg_type, [15:8] data_one, [23:16] data_two
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] out_channel, [12:5] out_type, [20:13] out_data_one,
                                  // [28:21] out_data_two, [36:29] held_count, [39:37] zero
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [4:0]        channel_r;
  logic signed [7:0] transpose_r;
  logic [2:0]        compress_r;
  logic signed [7:0] vel_offset_r;

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  mnep_pkg::cmd_t push_cmd;
  mnep_pkg::cmd_t pop_cmd;
  mnep_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r    <= 5'd1;
      transpose_r  <= 8'sd0;
      compress_r   <= mnep_pkg::CM_NONE;
      vel_offset_r <= 8'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mnep_pkg::CFG_CHANNEL:    channel_r    <= cfg_data[4:0];
        mnep_pkg::CFG_TRANSPOSE:  transpose_r  <= $signed(cfg_data);
        mnep_pkg::CFG_COMPRESS:   compress_r   <= cfg_data[2:0];
        mnep_pkg::CFG_VEL_OFFSET: vel_offset_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  mnep_front u_front (
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .transpose       (transpose_r),
    .compress_mode   (compress_r),
    .velocity_offset (vel_offset_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  mnep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .full      (q_full),
    .not_empty (q_valid)
  );

  mnep_back #(
    .MAX_RELEASE (MAX_RELEASE_PER_ITEM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .channel   (channel_r),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, res};

endmodule
